// ===== src/wli_pkg.sv =====
// ----------------------------------------------------------------------------
// wli_pkg
// Shared types and constants of the 3D waypoint interpolator: widths,
// register reset value, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package wli_pkg;

    // default geometry
    localparam int COORD_WIDTH_DEF = 22;
    localparam int MAX_STEPS_DEF   = 64;

    // step resolution register
    localparam int          RES_W     = 21;
    localparam logic [20:0] RES_RESET = 21'd13107;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_SINIT,
        S_SDIV,
        S_AINIT,
        S_ADIV,
        S_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_step;
        logic       sdiv_init;
        logic       sdiv_step;
        logic       adiv_init;
        logic       adiv_step;
        logic       emit_step;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic seg;       // accepted waypoint closes a segment
        logic out_free;  // output register can take a point
        logic last;      // next point is the final one of the segment
    } sts_t;

endpackage

`default_nettype wire

// ===== src/wli_if.sv =====
// ----------------------------------------------------------------------------
// wli_if
// Valid/ready channels: waypoint input and interpolated point output.
// ----------------------------------------------------------------------------
`default_nettype none

interface wli_wp_if #(parameter int W = 22);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_x;
    logic signed [W-1:0] in_y;
    logic signed [W-1:0] in_z;
    logic                path_start;

    modport source (output valid, in_x, in_y, in_z, path_start, input ready);
    modport sink   (input valid, in_x, in_y, in_z, path_start, output ready);
endinterface

interface wli_pt_if #(parameter int W = 22);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic signed [W-1:0] out_z;
    logic                segment_last;
    logic                steps_clipped;

    modport source (output valid, out_x, out_y, out_z, segment_last, steps_clipped,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, segment_last, steps_clipped,
                    output ready);
endinterface

`default_nettype wire

// ===== src/wli_dp.sv =====
// ----------------------------------------------------------------------------
// wli_dp
// Datapath: previous waypoint, deltas, squared distance, bit-serial square
// root, step count division, per-axis increment division and point stepping.
// ----------------------------------------------------------------------------
`default_nettype none

module wli_dp #(
    parameter int COORD_WIDTH = 22,
    parameter int MAX_STEPS   = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [wli_pkg::RES_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] in_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_z,
    input  wire logic                          path_start,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      out_x,
    output logic signed [COORD_WIDTH-1:0]      out_y,
    output logic signed [COORD_WIDTH-1:0]      out_z,
    output logic                               segment_last,
    output logic                               steps_clipped,
    input  wire wli_pkg::cmd_t                 cmd,
    output wli_pkg::sts_t                      sts
);
    import wli_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int SW  = 2 * CW + 2;           // squared distance width
    localparam int RTW = CW + 1;               // root width
    localparam int RMW = CW + 2;               // root remainder width
    localparam int SBW = $clog2(MAX_STEPS + 1);

    logic              accept;
    logic [CW-1:0]     in_c   [3];

    // waypoint state
    logic [CW-1:0]     prev_reg  [3];
    logic              have_prev_reg;
    logic [CW-1:0]     start_reg [3];
    logic [CW-1:0]     mag_reg   [3];
    logic              neg_reg   [3];

    // distance
    logic [SW-1:0]     sum_reg;
    logic [RTW-1:0]    root_reg;
    logic [RMW-1:0]    rem_reg;

    // step count division
    logic [RTW-1:0]    sq_reg;
    logic [RES_W-1:0]  sr_reg;
    logic [RES_W-1:0]  res_reg;
    logic [RES_W-1:0]  res_eff;

    // axis division and stepping
    logic [SBW-1:0]    steps_reg;
    logic              clip_reg;
    logic [CW-1:0]     aq_reg [3];
    logic [SBW-1:0]    ar_reg [3];
    logic [CW-1:0]     qa_reg [3];
    logic [SBW-1:0]    ra_reg [3];
    logic [SBW-1:0]    j_reg;

    // output register
    logic              out_valid_reg;
    logic [CW-1:0]     out_reg [3];
    logic              out_last_reg;
    logic              out_clip_reg;

    // combinational
    logic [CW:0]       delta  [3];
    logic [CW-1:0]     mag_sel;
    logic [2*CW-1:0]   prod;
    logic [RMW+1:0]    rt_sh;
    logic [RMW+1:0]    rt_trial;
    logic [RES_W:0]    sd_sh;
    logic [SBW:0]      ad_sh  [3];
    logic [SBW:0]      r_sum  [3];
    logic              r_ge   [3];
    logic [CW:0]       pt     [3];
    logic [SBW-1:0]    steps_next;

    assign accept  = in_valid && cmd.in_ready;
    assign in_c[0] = in_x;
    assign in_c[1] = in_y;
    assign in_c[2] = in_z;
    assign res_eff = (res_reg == '0) ? RES_W'(1) : res_reg;

    // deltas, squaring and per-lane arithmetic
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            delta[l] = {in_c[l][CW-1], in_c[l]} - {prev_reg[l][CW-1], prev_reg[l]};
            ad_sh[l] = {ar_reg[l], aq_reg[l][CW-1]};
            r_sum[l] = {1'b0, ra_reg[l]} + {1'b0, ar_reg[l]};
            r_ge[l]  = r_sum[l] >= {1'b0, steps_reg};
            if (neg_reg[l])
                pt[l] = {start_reg[l][CW-1], start_reg[l]} - {1'b0, qa_reg[l]};
            else
                pt[l] = {start_reg[l][CW-1], start_reg[l]} + {1'b0, qa_reg[l]};
        end
        case (cmd.sq_sel)
            2'd0:    mag_sel = mag_reg[0];
            2'd1:    mag_sel = mag_reg[1];
            default: mag_sel = mag_reg[2];
        endcase
        prod     = mag_sel * mag_sel;
        rt_sh    = {rem_reg, sum_reg[SW-1:SW-2]};
        rt_trial = {1'b0, root_reg, 2'b01};
        sd_sh    = {sr_reg, sq_reg[RTW-1]};
        if (sq_reg == '0)
            steps_next = SBW'(1);
        else if (sq_reg > RTW'(MAX_STEPS))
            steps_next = SBW'(MAX_STEPS);
        else
            steps_next = sq_reg[SBW-1:0];
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= RES_RESET;
            for (int l = 0; l < 3; l++)
                prev_reg[l] <= '0;
        end
        else
        begin
            if (cfg_we)
                res_reg <= cfg_data;
            if (accept)
            begin
                have_prev_reg <= 1'b1;
                for (int l = 0; l < 3; l++)
                    prev_reg[l] <= in_c[l];
            end
            if (cmd.emit_step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
            for (int l = 0; l < 3; l++)
            begin
                start_reg[l] <= prev_reg[l];
                neg_reg[l]   <= delta[l][CW];
                mag_reg[l]   <= delta[l][CW] ? CW'(-delta[l]) : delta[l][CW-1:0];
            end
        end
        // squared distance, one axis per cycle
        if (cmd.sq_step)
            sum_reg <= sum_reg + SW'(prod);
        // square root, one result bit per cycle
        if (cmd.root_step)
        begin
            sum_reg <= sum_reg << 2;
            if (rt_sh >= rt_trial)
            begin
                rem_reg  <= RMW'(rt_sh - rt_trial);
                root_reg <= {root_reg[RTW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rt_sh[RMW-1:0];
                root_reg <= {root_reg[RTW-2:0], 1'b0};
            end
        end
        // distance over resolution, restoring
        if (cmd.sdiv_init)
        begin
            sq_reg <= root_reg;
            sr_reg <= '0;
        end
        if (cmd.sdiv_step)
        begin
            if (sd_sh >= {1'b0, res_eff})
            begin
                sr_reg <= RES_W'(sd_sh - {1'b0, res_eff});
                sq_reg <= {sq_reg[RTW-2:0], 1'b1};
            end
            else
            begin
                sr_reg <= sd_sh[RES_W-1:0];
                sq_reg <= {sq_reg[RTW-2:0], 1'b0};
            end
        end
        // step count and axis division setup
        if (cmd.adiv_init)
        begin
            steps_reg <= steps_next;
            clip_reg  <= sq_reg > RTW'(MAX_STEPS);
            j_reg     <= '0;
            for (int l = 0; l < 3; l++)
            begin
                aq_reg[l] <= mag_reg[l];
                ar_reg[l] <= '0;
                qa_reg[l] <= '0;
                ra_reg[l] <= '0;
            end
        end
        // magnitude over steps, three lanes
        if (cmd.adiv_step)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (ad_sh[l] >= {1'b0, steps_reg})
                begin
                    ar_reg[l] <= SBW'(ad_sh[l] - {1'b0, steps_reg});
                    aq_reg[l] <= {aq_reg[l][CW-2:0], 1'b1};
                end
                else
                begin
                    ar_reg[l] <= ad_sh[l][SBW-1:0];
                    aq_reg[l] <= {aq_reg[l][CW-2:0], 1'b0};
                end
            end
        end
        // emit a point and advance the offsets
        if (cmd.emit_step)
        begin
            out_last_reg <= sts.last;
            out_clip_reg <= clip_reg;
            j_reg        <= j_reg + SBW'(1);
            for (int l = 0; l < 3; l++)
            begin
                out_reg[l] <= pt[l][CW-1:0];
                if (r_ge[l])
                begin
                    qa_reg[l] <= qa_reg[l] + aq_reg[l] + CW'(1);
                    ra_reg[l] <= SBW'(r_sum[l] - {1'b0, steps_reg});
                end
                else
                begin
                    qa_reg[l] <= qa_reg[l] + aq_reg[l];
                    ra_reg[l] <= r_sum[l][SBW-1:0];
                end
            end
        end
    end

    assign sts.seg      = !path_start && have_prev_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.last     = ({1'b0, j_reg} + (SBW+1)'(1)) == {1'b0, steps_reg};

    assign out_valid     = out_valid_reg;
    assign out_x         = out_reg[0];
    assign out_y         = out_reg[1];
    assign out_z         = out_reg[2];
    assign segment_last  = out_last_reg;
    assign steps_clipped = out_clip_reg;

    // checks
    a_steps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> steps_reg != '0)
        else $error("step count zero while emitting");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> ra_reg[0] < steps_reg && ra_reg[1] < steps_reg)
        else $error("offset remainder out of range");
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |=> out_valid_reg)
        else $error("emitted point not presented");

endmodule

`default_nettype wire

// ===== src/wli_ctrl.sv =====
// ----------------------------------------------------------------------------
// wli_ctrl
// Controller: sequences squaring, square root, divisions and point emission.
// ----------------------------------------------------------------------------
`default_nettype none

module wli_ctrl #(
    parameter int COORD_WIDTH = 22
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire wli_pkg::sts_t sts,
    output wli_pkg::cmd_t      cmd
);
    import wli_pkg::*;

    localparam int CNT_W = $clog2(COORD_WIDTH + 2);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        cmd        = '0;
        cmd.sq_sel = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cnt_next     = '0;
                if (in_valid && sts.seg)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == CNT_W'(2))
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_W'(COORD_WIDTH))
                    state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.sdiv_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SDIV;
            end
            S_SDIV:
            begin
                cmd.sdiv_step = 1'b1;
                if (cnt_reg == CNT_W'(COORD_WIDTH))
                    state_next = S_AINIT;
            end
            S_AINIT:
            begin
                cmd.adiv_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_ADIV;
            end
            S_ADIV:
            begin
                cmd.adiv_step = 1'b1;
                if (cnt_reg == CNT_W'(COORD_WIDTH - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_step = sts.out_free;
                if (sts.out_free && sts.last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && sts.out_free && sts.last) |=> state_reg == S_IDLE)
        else $error("segment did not end after final point");

endmodule

`default_nettype wire

// ===== src/waypoint_linear_interpolator_3d.sv =====
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator_3d
// Turns a waypoint stream into evenly spaced points on each straight segment.
//
//   channel   dir  handshake     payload
//   wp_in     in   valid/ready   in_x, in_y, in_z, path_start
//   pt_out    out  valid/ready   out_x, out_y, out_z, segment_last, steps_clipped
//   cfg       in   cfg_we        cfg_data = step_resolution
//
// A path start waypoint only primes the previous point. A segment runs setup
// (transfer, squaring, bit-serial root, two restoring dividers), then emits
// one point per cycle, up to MAX_STEPS. Output stalls hold the emitter; the
// last point sits in the output register while the next waypoint is taken.
// Reset is async.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_linear_interpolator_3d #(
    parameter int COORD_WIDTH = wli_pkg::COORD_WIDTH_DEF,
    parameter int MAX_STEPS   = wli_pkg::MAX_STEPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [wli_pkg::RES_W-1:0] cfg_data,
    wli_wp_if.sink                         wp_in,
    wli_pt_if.source                       pt_out
);
    import wli_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign wp_in.ready = cmd.in_ready;

    // sequencer
    wli_ctrl #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (wp_in.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic
    wli_dp #(
        .COORD_WIDTH(COORD_WIDTH),
        .MAX_STEPS  (MAX_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (wp_in.valid),
        .in_x          (wp_in.in_x),
        .in_y          (wp_in.in_y),
        .in_z          (wp_in.in_z),
        .path_start    (wp_in.path_start),
        .out_valid     (pt_out.valid),
        .out_ready     (pt_out.ready),
        .out_x         (pt_out.out_x),
        .out_y         (pt_out.out_y),
        .out_z         (pt_out.out_z),
        .segment_last  (pt_out.segment_last),
        .steps_clipped (pt_out.steps_clipped),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire
